// File: sv/pfe_pkg.sv
package pfe_pkg;

  localparam int unsigned SquareSide  = 5;
  localparam int unsigned LetterCount = 26;
  localparam int unsigned LetterW     = 5;

  localparam logic [LetterW-1:0] LetterI = LetterW'(8);
  localparam logic [LetterW-1:0] LetterJ = LetterW'(9);
  localparam logic [LetterW-1:0] LetterZ = LetterW'(25);

  typedef enum logic [1:0] {
    OpClear   = 2'd0,
    OpKey     = 2'd1,
    OpFinish  = 2'd2,
    OpEncrypt = 2'd3
  } op_e;

  // codes above Z read as Z, J reads as I
  function automatic logic [LetterW-1:0] norm_letter(input logic [LetterW-1:0] raw);
    logic [LetterW-1:0] v;
    v = raw;
    if (v > LetterZ) v = LetterZ;
    if (v == LetterJ) v = LetterI;
    return v;
  endfunction

endpackage

// File: sv/pfe_ram.sv
module pfe_ram #(
  parameter int unsigned WIDTH = pfe_pkg::LetterW,
  parameter int unsigned DEPTH = pfe_pkg::LetterCount
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// File: sv/playfair_pair_encryptor.sv
// Clear and key-letter commands complete at their transfer edge; busy never rises.
// Finish walks the alphabet one letter per cycle, with busy high for the whole walk.
// Encrypt on a finished square: two position reads, then two cell reads, through
// StPos and StCell with busy high; the result strobe is registered from StCell (no back-pressure).
// Encrypt on an unfinished square strobes the flagged result in the next cycle.
// Reset clears used-letter map, fill count and done flag; RAM contents are kept.
module playfair_pair_encryptor #(
  parameter int unsigned SQUARE_SIDE = pfe_pkg::SquareSide
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  operation_i,
  input  logic [pfe_pkg::LetterW-1:0] letter_a_i,
  input  logic [pfe_pkg::LetterW-1:0] letter_b_i,
  output logic                        result_valid_o,
  output logic [pfe_pkg::LetterW-1:0] cipher_a_o,
  output logic [pfe_pkg::LetterW-1:0] cipher_b_o,
  output logic                        square_incomplete_o
);

  localparam int unsigned CellCount = SQUARE_SIDE * SQUARE_SIDE;
  localparam int unsigned CellW     = $clog2(CellCount);
  localparam int unsigned FillW     = $clog2(CellCount + 1);
  localparam int unsigned RowW      = $clog2(SQUARE_SIDE);
  localparam int unsigned LW        = pfe_pkg::LetterW;
  localparam int unsigned NLetters  = pfe_pkg::LetterCount;

  typedef enum logic [1:0] {
    StIdle,
    StFill,
    StPos,
    StCell
  } state_e;

  state_e             state_q;
  logic [FillW-1:0]   fill_q;
  logic [NLetters-1:0] used_q;
  logic               done_q;
  logic [LW-1:0]      idx_q;
  logic               valid_q;
  logic               valid_d;
  logic [LW-1:0]      cipher_a_q;
  logic [LW-1:0]      cipher_b_q;
  logic               incomplete_q;

  logic          xfer;
  logic [LW-1:0] na;
  logic [LW-1:0] nb;
  logic          room;
  logic          key_place;
  logic          walk_place;
  logic          place;
  logic [LW-1:0] place_letter;

  logic [CellW-1:0] pos_a;
  logic [CellW-1:0] pos_b;
  logic [LW-1:0]    cell_a;
  logic [LW-1:0]    cell_b;
  logic [RowW-1:0]  ra, ca, rb, cb;
  logic [RowW-1:0]  ra_n, ca_n, rb_n, cb_n;
  logic [RowW-1:0]  xr_a, xc_a, xr_b, xc_b;
  logic [CellW-1:0] idx_a, idx_b;

  assign busy = (state_q != StIdle);
  assign xfer = start && !busy;
  assign na   = pfe_pkg::norm_letter(letter_a_i);
  assign nb   = pfe_pkg::norm_letter(letter_b_i);
  assign room = (fill_q < FillW'(CellCount));

  assign key_place  = xfer && (operation_i == pfe_pkg::OpKey) && !done_q && !used_q[na] && room;
  assign walk_place = (state_q == StFill) && (idx_q != pfe_pkg::LetterJ) && !used_q[idx_q] && room;
  assign place        = key_place || walk_place;
  assign place_letter = key_place ? na : idx_q;

  assign valid_d = (xfer && (operation_i == pfe_pkg::OpEncrypt) && !done_q) ||
                   (state_q == StCell);

  pfe_ram #(
    .WIDTH(LW),
    .DEPTH(CellCount)
  ) u_square_ram (
    .clk_i    (clk_i),
    .we_i     (place),
    .waddr_i  (fill_q[CellW-1:0]),
    .wdata_i  (place_letter),
    .raddr_a_i(idx_a),
    .raddr_b_i(idx_b),
    .rdata_a_o(cell_a),
    .rdata_b_o(cell_b)
  );

  pfe_ram #(
    .WIDTH(CellW),
    .DEPTH(NLetters)
  ) u_pos_ram (
    .clk_i    (clk_i),
    .we_i     (place),
    .waddr_i  (place_letter),
    .wdata_i  (fill_q[CellW-1:0]),
    .raddr_a_i(na),
    .raddr_b_i(nb),
    .rdata_a_o(pos_a),
    .rdata_b_o(pos_b)
  );

  // cell index to row and column by compare against row starts
  always_comb begin
    ra = '0;
    rb = '0;
    for (int r = 1; r < SQUARE_SIDE; r++) begin
      if (pos_a >= CellW'(r * SQUARE_SIDE)) ra = RowW'(r);
      if (pos_b >= CellW'(r * SQUARE_SIDE)) rb = RowW'(r);
    end
    ca = RowW'(pos_a - CellW'(ra * SQUARE_SIDE));
    cb = RowW'(pos_b - CellW'(rb * SQUARE_SIDE));
  end

  assign ra_n = (ra == RowW'(SQUARE_SIDE - 1)) ? '0 : RowW'(ra + 1'b1);
  assign rb_n = (rb == RowW'(SQUARE_SIDE - 1)) ? '0 : RowW'(rb + 1'b1);
  assign ca_n = (ca == RowW'(SQUARE_SIDE - 1)) ? '0 : RowW'(ca + 1'b1);
  assign cb_n = (cb == RowW'(SQUARE_SIDE - 1)) ? '0 : RowW'(cb + 1'b1);

  always_comb begin
    if (ra == rb) begin
      xr_a = ra;   xc_a = ca_n;
      xr_b = rb;   xc_b = cb_n;
    end else if (ca == cb) begin
      xr_a = ra_n; xc_a = ca;
      xr_b = rb_n; xc_b = cb;
    end else begin
      xr_a = ra;   xc_a = cb;
      xr_b = rb;   xc_b = ca;
    end
  end

  assign idx_a = CellW'(xr_a * SQUARE_SIDE + xc_a);
  assign idx_b = CellW'(xr_b * SQUARE_SIDE + xc_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      fill_q       <= '0;
      used_q       <= '0;
      done_q       <= 1'b0;
      idx_q        <= '0;
      valid_q      <= 1'b0;
      cipher_a_q   <= '0;
      cipher_b_q   <= '0;
      incomplete_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (place) begin
        used_q[place_letter] <= 1'b1;
        fill_q               <= FillW'(fill_q + 1'b1);
      end
      case (state_q)
        StIdle: begin
          if (xfer) begin
            case (operation_i)
              pfe_pkg::OpClear: begin
                used_q <= '0;
                fill_q <= '0;
                done_q <= 1'b0;
              end
              pfe_pkg::OpFinish: begin
                if (!done_q) begin
                  idx_q   <= '0;
                  state_q <= StFill;
                end
              end
              pfe_pkg::OpEncrypt: begin
                if (done_q) begin
                  state_q <= StPos;
                end else begin
                  cipher_a_q   <= '0;
                  cipher_b_q   <= '0;
                  incomplete_q <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        StFill: begin
          idx_q <= LW'(idx_q + 1'b1);
          if (idx_q == LW'(NLetters - 1)) begin
            done_q  <= 1'b1;
            state_q <= StIdle;
          end
        end
        StPos: begin
          state_q <= StCell;
        end
        StCell: begin
          cipher_a_q   <= cell_a;
          cipher_b_q   <= cell_b;
          incomplete_q <= 1'b0;
          state_q      <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign result_valid_o      = valid_q;
  assign cipher_a_o          = cipher_a_q;
  assign cipher_b_o          = cipher_b_q;
  assign square_incomplete_o = incomplete_q;

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (state_q == StIdle))
    else $error("result strobe while busy");

  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && incomplete_q) |-> (cipher_a_q == '0 && cipher_b_q == '0))
    else $error("flagged result carries letters");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(CellCount))
    else $error("fill count past square size");

  a_done_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> (fill_q == FillW'(CellCount)))
    else $error("square finished but not full");

endmodule

// File: test/pfe_cipher_checker.sv
module pfe_cipher_checker
  import pfe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         operation_i,
  input  logic [LetterW-1:0] letter_a_i,
  input  logic [LetterW-1:0] letter_b_i,
  input  logic               result_valid_i,
  input  logic [LetterW-1:0] cipher_a_i,
  input  logic [LetterW-1:0] cipher_b_i,
  input  logic               square_incomplete_i,
  output int                 errors_o,
  output int                 outstanding_o,
  output int                 checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Cells = SquareSide * SquareSide;

  typedef struct packed {
    logic [LetterW-1:0] ca;
    logic [LetterW-1:0] cb;
    logic               incomplete;
  } cipher_t;

  cipher_t            cipher_pending[$];
  logic [LetterW-1:0] square_cell[Cells];
  logic [LetterW-1:0] letter_cell[LetterCount];
  bit                 letter_placed[LetterCount];
  int                 cells_filled;
  bit                 square_ready;

  initial begin
    errors_o      = 0;
    outstanding_o = 0;
    checked_o     = 0;
    cells_filled  = 0;
    square_ready  = 0;
    foreach (square_cell[i]) square_cell[i] = '0;
    foreach (letter_cell[i]) begin
      letter_cell[i]   = '0;
      letter_placed[i] = 0;
    end
  end

  // J shares the I cell, codes past Z read as Z
  function automatic int fold_code(logic [LetterW-1:0] code);
    if (code >= LetterCount) return int'(LetterZ);
    return (code == LetterJ) ? int'(LetterI) : int'(code);
  endfunction

  task automatic place(int code);
    if (letter_placed[code] || cells_filled >= Cells) return;
    square_cell[cells_filled] = LetterW'(cells_filled == 0 ? code : code);
    letter_cell[code]         = LetterW'(cells_filled);
    letter_placed[code]       = 1;
    cells_filled++;
  endtask

  function automatic cipher_t encrypt_pair(int a, int b);
    cipher_t r;
    int pa, pb, ra, ca, rb, cb;
    r  = '0;
    pa = int'(letter_cell[a]) % Cells;
    pb = int'(letter_cell[b]) % Cells;
    ra = pa / SquareSide;
    ca = pa % SquareSide;
    rb = pb / SquareSide;
    cb = pb % SquareSide;
    if (ra == rb) begin
      r.ca = square_cell[ra * SquareSide + (ca + 1) % SquareSide];
      r.cb = square_cell[rb * SquareSide + (cb + 1) % SquareSide];
    end else if (ca == cb) begin
      r.ca = square_cell[((ra + 1) % SquareSide) * SquareSide + ca];
      r.cb = square_cell[((rb + 1) % SquareSide) * SquareSide + cb];
    end else begin
      r.ca = square_cell[ra * SquareSide + cb];
      r.cb = square_cell[rb * SquareSide + ca];
    end
    return r;
  endfunction

  task automatic predict(op_e op, logic [LetterW-1:0] a, logic [LetterW-1:0] b);
    cipher_t r;
    case (op)
      OpClear: begin
        foreach (letter_placed[i]) letter_placed[i] = 0;
        cells_filled = 0;
        square_ready = 0;
      end
      OpKey: begin
        if (!square_ready) place(fold_code(a));
      end
      OpFinish: begin
        if (!square_ready) begin
          for (int i = 0; i < LetterCount; i++)
            if (i != int'(LetterJ)) place(i);
          square_ready = 1;
        end
      end
      default: begin
        if (!square_ready) begin
          r = '0;
          r.incomplete = 1'b1;
        end else begin
          r = encrypt_pair(fold_code(a), fold_code(b));
        end
        cipher_pending.push_back(r);
      end
    endcase
  endtask

  task automatic compare_result();
    cipher_t e;
    if (cipher_pending.size() == 0) begin
      $display("%0t: result with nothing expected: expected none, actual a=%0d b=%0d inc=%0d",
               $time, cipher_a_i, cipher_b_i, square_incomplete_i);
      errors_o++;
      return;
    end
    e = cipher_pending.pop_front();
    checked_o++;
    if (cipher_a_i !== e.ca) begin
      $display("%0t: cipher_a mismatch: expected %0d, actual %0d", $time, e.ca, cipher_a_i);
      errors_o++;
    end
    if (cipher_b_i !== e.cb) begin
      $display("%0t: cipher_b mismatch: expected %0d, actual %0d", $time, e.cb, cipher_b_i);
      errors_o++;
    end
    if (square_incomplete_i !== e.incomplete) begin
      $display("%0t: square_incomplete mismatch: expected %0d, actual %0d",
               $time, e.incomplete, square_incomplete_i);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (letter_placed[i]) letter_placed[i] = 0;
      cells_filled = 0;
      square_ready = 0;
      cipher_pending.delete();
    end else begin
      if (result_valid_i === 1'b1) compare_result();
      if (start_i && busy_i === 1'b0) predict(op_e'(operation_i), letter_a_i, letter_b_i);
    end
    outstanding_o = cipher_pending.size();
  end

endmodule

// File: test/tb_top.sv
module tb_top;
  import pfe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         operation_i = 2'd0;
  logic [LetterW-1:0] letter_a_i = '0;
  logic [LetterW-1:0] letter_b_i = '0;
  logic               result_valid_o;
  logic [LetterW-1:0] cipher_a_o;
  logic [LetterW-1:0] cipher_b_o;
  logic               square_incomplete_o;

  int errors;
  int outstanding;
  int checked;
  int sent = 0;
  bit gaps_on = 1;

  playfair_pair_encryptor uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .operation_i        (operation_i),
    .letter_a_i         (letter_a_i),
    .letter_b_i         (letter_b_i),
    .result_valid_o     (result_valid_o),
    .cipher_a_o         (cipher_a_o),
    .cipher_b_o         (cipher_b_o),
    .square_incomplete_o(square_incomplete_o)
  );

  pfe_cipher_checker chk (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .busy_i             (busy),
    .operation_i        (operation_i),
    .letter_a_i         (letter_a_i),
    .letter_b_i         (letter_b_i),
    .result_valid_i     (result_valid_o),
    .cipher_a_i         (cipher_a_o),
    .cipher_b_i         (cipher_b_o),
    .square_incomplete_i(square_incomplete_o),
    .errors_o           (errors),
    .outstanding_o      (outstanding),
    .checked_o          (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic issue(op_e op, logic [LetterW-1:0] a, logic [LetterW-1:0] b);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start       = 1'b0;
      operation_i = 2'($urandom_range(0, 3));
      letter_a_i  = LetterW'($urandom_range(0, 31));
      letter_b_i  = LetterW'($urandom_range(0, 31));
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    start       = 1'b1;
    operation_i = op;
    letter_a_i  = a;
    letter_b_i  = b;
    do @(posedge clk_i); while (busy !== 1'b0);
    @(negedge clk_i);
    sent++;
  endtask

  function automatic logic [LetterW-1:0] any_code();
    return LetterW'($urandom_range(0, 31));
  endfunction

  task automatic drain();
    start = 1'b0;
    while (outstanding != 0 || busy !== 1'b0) @(negedge clk_i);
  endtask

  // usually clear, keys, usually finish, then a run of pairs with an occasional key or finish among them
  task automatic key_session();
    int nkeys;
    int npairs;
    if ($urandom_range(0, 9) != 0) issue(OpClear, any_code(), any_code());
    nkeys = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 32) : $urandom_range(0, 10);
    for (int i = 0; i < nkeys; i++) begin
      issue(OpKey, any_code(), any_code());
      if ($urandom_range(0, 19) == 0) issue(OpEncrypt, any_code(), any_code());
    end
    if ($urandom_range(0, 19) != 0) issue(OpFinish, any_code(), any_code());
    npairs = $urandom_range(1, 12);
    for (int i = 0; i < npairs; i++) begin
      if ($urandom_range(0, 15) == 0)
        issue(op_e'($urandom_range(1, 2)), any_code(), any_code());
      else
        issue(OpEncrypt, any_code(), any_code());
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    issue(OpEncrypt, 5'd0, 5'd25);
    issue(OpKey, 5'd31, 5'd0);
    issue(OpKey, 5'd9, 5'd31);
    issue(OpKey, 5'd8, 5'd0);
    issue(OpKey, 5'd0, 5'd0);
    issue(OpKey, 5'd26, 5'd0);
    issue(OpFinish, 5'd0, 5'd0);
    issue(OpFinish, 5'd31, 5'd31);
    issue(OpKey, 5'd5, 5'd0);
    issue(OpEncrypt, 5'd0, 5'd0);
    issue(OpEncrypt, 5'd9, 5'd8);
    issue(OpEncrypt, 5'd31, 5'd0);
    issue(OpEncrypt, 5'd25, 5'd3);
    issue(OpEncrypt, 5'd1, 5'd7);
    issue(OpEncrypt, 5'd24, 5'd4);
    issue(OpClear, 5'd31, 5'd31);
    issue(OpEncrypt, 5'd2, 5'd3);
    issue(OpFinish, 5'd0, 5'd0);
    issue(OpEncrypt, 5'd0, 5'd4);
    issue(OpEncrypt, 5'd0, 5'd21);
    issue(OpEncrypt, 5'd25, 5'd25);
    issue(OpEncrypt, 5'd31, 5'd30);
    issue(OpEncrypt, 5'd16, 5'd9);
    drain();

    while (sent < 2000) begin
      gaps_on = (sent < 1700);
      if ($urandom_range(0, 9) == 0)
        issue(op_e'($urandom_range(0, 3)), any_code(), any_code());
      else
        key_session();
      if (sent % 400 < 15) drain();
    end

    start = 1'b0;
    drain();
    repeat (40) @(negedge clk_i);
    $display("%0d commands transferred, %0d cipher results checked", sent, checked);
    $display("keys with repeats, J and out-of-range codes, early encrypts, all pair rules");
    if (errors == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
sv/pfe_pkg.sv
sv/pfe_ram.sv
sv/playfair_pair_encryptor.sv
test/pfe_cipher_checker.sv
test/tb_top.sv
